@@ hdl/mlf_pkg.sv @@
// ----------------------------------------------------------------------------
// mlf_pkg
// Shared types and fixed codes of the four-pole ladder lowpass filter.
// ----------------------------------------------------------------------------
package mlf_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLE_COEF     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INPUT_COEF    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_GAIN = 2'd2;

    // request kinds
    localparam logic REQ_FILTER = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    localparam int NUM_STAGES   = 4;
    localparam int CLIP_DIVISOR = 6;

    // final shift applied to the accumulator
    typedef enum logic [1:0] {
        SHIFT_COEF,
        SHIFT_FRAC,
        SHIFT_RECIP
    } shift_sel_t;

    // one product issued to the multiply-accumulate unit
    typedef struct packed {
        logic       issue;
        logic       first;
        logic       last;
        logic       neg;
        logic       round;
        logic       sub_base;
        logic       sat_en;
        shift_sel_t shift;
    } mac_ctrl_t;

    // result status back from the unit
    typedef struct packed {
        logic valid;
        logic sat;
    } mac_status_t;

endpackage

@@ hdl/mlf_if.sv @@
// ----------------------------------------------------------------------------
// mlf channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mlf_req_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output req_type, output sample_in, input ready);
    modport sink (input valid, input req_type, input sample_in, output ready);
endinterface

interface mlf_res_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

interface mlf_cfg_if #(parameter int DATA_W = 19);
    logic                               valid;
    logic                               ready;
    logic [mlf_pkg::CFG_INDEX_W-1:0]    index;
    logic [DATA_W-1:0]                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/mlf_mac_unit.sv @@
// ----------------------------------------------------------------------------
// mlf_mac_unit
// Shared multiply-accumulate unit with rounding shift, subtract and saturate.
// ----------------------------------------------------------------------------
module mlf_mac_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16,
    localparam int FRAC_BITS     = SAMPLE_BITS - 4,
    localparam int SQ_W          = SAMPLE_BITS + 3,
    localparam int RECIP_SHIFT   = SQ_W + $clog2(mlf_pkg::CLIP_DIVISOR),
    localparam int A_W           = (COEF_FRAC_BITS + 4 > SQ_W + 1) ?
                                   COEF_FRAC_BITS + 4 : SQ_W + 1,
    localparam int B_W           = SQ_W + 2,
    localparam int RES_W         = SQ_W + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mlf_pkg::mac_ctrl_t            op,
    input  logic signed [A_W-1:0]         a,
    input  logic signed [B_W-1:0]         b,
    input  logic signed [SAMPLE_BITS-1:0] base,
    output logic signed [RES_W-1:0]       res,
    output mlf_pkg::mac_status_t          status
);

    localparam int PROD_W = A_W + B_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam logic [ACC_W-1:0] ONE = {{(ACC_W-1){1'b0}}, 1'b1};
    localparam logic [ACC_W-1:0] HALF_COEF = ONE << (COEF_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] HALF_FRAC = ONE << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    mlf_pkg::mac_ctrl_t            ctl1_reg;
    mlf_pkg::mac_ctrl_t            ctl2_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [SAMPLE_BITS-1:0] base1_reg;
    logic signed [SAMPLE_BITS-1:0] base2_reg;
    logic signed [RES_W-1:0]       res_reg;
    logic signed [RES_W-1:0]       res_next;
    logic                          res_valid_reg;
    logic                          res_sat_reg;
    logic                          res_sat_next;
    logic signed [ACC_W-1:0]       acc_init;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       shifted;
    logic signed [ACC_W-1:0]       diff;

    // rounding offset preloaded on the first product of an operation
    always_comb
    begin
        acc_init = '0;
        if (ctl1_reg.round)
        begin
            case (ctl1_reg.shift)
                mlf_pkg::SHIFT_COEF: acc_init = $signed(HALF_COEF);
                mlf_pkg::SHIFT_FRAC: acc_init = $signed(HALF_FRAC);
                default:             acc_init = '0;
            endcase
        end
        prod_ext = ACC_W'(prod_reg);
        acc_next = (ctl1_reg.first ? acc_init : acc_reg) +
                   (ctl1_reg.neg ? -prod_ext : prod_ext);
    end

    // final shift, optional subtract from base, saturate
    always_comb
    begin
        case (ctl2_reg.shift)
            mlf_pkg::SHIFT_COEF:  shifted = acc_reg >>> COEF_FRAC_BITS;
            mlf_pkg::SHIFT_FRAC:  shifted = acc_reg >>> FRAC_BITS;
            mlf_pkg::SHIFT_RECIP: shifted = acc_reg >>> RECIP_SHIFT;
            default:              shifted = acc_reg;
        endcase
        diff = ctl2_reg.sub_base ? (ACC_W'(base2_reg) - shifted) : shifted;
        res_next     = diff[RES_W-1:0];
        res_sat_next = 1'b0;
        if (ctl2_reg.sat_en)
        begin
            if (diff > SAT_HI)
            begin
                res_next     = SAT_HI[RES_W-1:0];
                res_sat_next = 1'b1;
            end
            else if (diff < SAT_LO)
            begin
                res_next     = SAT_LO[RES_W-1:0];
                res_sat_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg      <= '0;
            ctl2_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_sat_reg   <= 1'b0;
        end
        else
        begin
            ctl1_reg      <= op;
            ctl2_reg      <= ctl1_reg;
            res_valid_reg <= ctl2_reg.issue && ctl2_reg.last;
            if (ctl2_reg.issue && ctl2_reg.last)
            begin
                res_sat_reg <= res_sat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.issue)
        begin
            prod_reg  <= a * b;
            base1_reg <= base;
        end
        if (ctl1_reg.issue)
        begin
            acc_reg   <= acc_next;
            base2_reg <= base1_reg;
        end
        if (ctl2_reg.issue && ctl2_reg.last)
        begin
            res_reg <= res_next;
        end
    end

    assign res           = res_reg;
    assign status.valid  = res_valid_reg;
    assign status.sat    = res_sat_reg;

endmodule

@@ hdl/moog_ladder_lowpass_filter_core.sv @@
// a filter request holds the core busy until its result is registered, and no
// new request is accepted meanwhile, the work being a chain of eight
//   dependent operations through the one shared multiply-accumulate unit
// a clear request is completed when it is accepted and gives no result
// reset: coefficients and filter history cleared to zero, no result pending
// ----------------------------------------------------------------------------
// moog_ladder_lowpass_filter_core
// Four-pole resonant ladder lowpass with cubic soft clipper, computed by a
// step sequencer driving one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module moog_ladder_lowpass_filter_core #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    mlf_req_if.sink    request,
    mlf_res_if.source  result,
    mlf_cfg_if.sink    cfg
);

    // coefficient and datapath widths
    localparam int K_W         = COEF_FRAC_BITS + 2;
    localparam int P_W         = COEF_FRAC_BITS + 1;
    localparam int R_W         = COEF_FRAC_BITS + 3;
    localparam int SQ_W        = SAMPLE_BITS + 3;
    localparam int RECIP_SHIFT = SQ_W + $clog2(mlf_pkg::CLIP_DIVISOR);
    localparam int A_W         = (COEF_FRAC_BITS + 4 > SQ_W + 1) ?
                                 COEF_FRAC_BITS + 4 : SQ_W + 1;
    localparam int B_W         = SQ_W + 2;
    localparam int RES_W       = SQ_W + 1;
    localparam int NUM_STAGES  = mlf_pkg::NUM_STAGES;

    // reciprocal of the clipper divisor, exact for any square below 2^SQ_W
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + mlf_pkg::CLIP_DIVISOR - 1) / mlf_pkg::CLIP_DIVISOR;
    localparam logic [B_W-1:0] RECIP_B = B_W'(RECIP_FULL);

    // step schedule: a result is used once it has passed the unit's product, accumulator and result registers
    localparam int MAC_LAT     = 3;
    localparam int STAGE_STEPS = 3;
    localparam int S_FB        = 0;
    localparam int S_ST0       = 1;
    localparam int S_SQ        = S_ST0 + NUM_STAGES * STAGE_STEPS - 1 + MAC_LAT;
    localparam int S_RECIP     = S_SQ + MAC_LAT;
    localparam int S_CUBE      = S_RECIP + MAC_LAT;
    localparam int S_DONE      = S_CUBE + MAC_LAT;
    localparam int STEP_W      = $clog2(S_DONE + 1);

    localparam logic [STEP_W-1:0] STEP_FB     = STEP_W'(S_FB);
    localparam logic [STEP_W-1:0] STEP_X_CAPT = STEP_W'(S_FB + MAC_LAT);
    localparam logic [STEP_W-1:0] STEP_SQ     = STEP_W'(S_SQ);
    localparam logic [STEP_W-1:0] STEP_RECIP  = STEP_W'(S_RECIP);
    localparam logic [STEP_W-1:0] STEP_CUBE   = STEP_W'(S_CUBE);
    localparam logic [STEP_W-1:0] STEP_DONE   = STEP_W'(S_DONE);

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                          state_reg;
    logic [STEP_W-1:0]             step_reg;

    // coefficient registers
    logic signed [K_W-1:0]         pole_reg;
    logic [P_W-1:0]                input_reg;
    logic [R_W-1:0]                gain_reg;

    // filter history: stage_reg[last] holds the clipped output
    logic signed [SAMPLE_BITS-1:0] prev_input_reg;
    logic signed [SAMPLE_BITS-1:0] stage_reg [NUM_STAGES];
    logic signed [SAMPLE_BITS-1:0] u_old [NUM_STAGES];

    // per-request working values
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] y3raw_reg;
    logic                          sat_reg;

    // result holding register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_sat_reg;

    // shared unit connection
    mlf_pkg::mac_ctrl_t            op;
    logic signed [A_W-1:0]         a_val;
    logic signed [B_W-1:0]         b_val;
    logic signed [SAMPLE_BITS-1:0] base_val;
    logic signed [RES_W-1:0]       res_val;
    mlf_pkg::mac_status_t          mac_stat;

    logic req_accept;
    logic slot_free;

    assign request.ready = (state_reg == ST_IDLE);
    assign req_accept    = request.valid && request.ready;
    assign cfg.ready     = 1'b1;
    assign slot_free     = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_sample_reg;
    assign result.saturated  = out_sat_reg;

    // stage inputs from the previous sample: x for the first, else stage outputs
    always_comb
    begin
        u_old[0] = prev_input_reg;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            u_old[i] = stage_reg[i-1];
        end
    end

    // product schedule
    always_comb
    begin
        op       = '0;
        a_val    = '0;
        b_val    = '0;
        base_val = '0;
        if (state_reg == ST_RUN)
        begin
            unique case (step_reg)
                STEP_FB:
                begin
                    // x = sat(sample - round(r * last output))
                    op.issue    = 1'b1;
                    op.first    = 1'b1;
                    op.last     = 1'b1;
                    op.round    = 1'b1;
                    op.sub_base = 1'b1;
                    op.sat_en   = 1'b1;
                    op.shift    = mlf_pkg::SHIFT_COEF;
                    a_val       = $signed(A_W'(gain_reg));
                    b_val       = B_W'(stage_reg[NUM_STAGES-1]);
                    base_val    = sample_reg;
                end
                STEP_SQ:
                begin
                    // square of the last stage output
                    op.issue = 1'b1;
                    op.first = 1'b1;
                    op.last  = 1'b1;
                    op.round = 1'b1;
                    op.shift = mlf_pkg::SHIFT_FRAC;
                    a_val    = A_W'(res_val);
                    b_val    = B_W'(res_val);
                end
                STEP_RECIP:
                begin
                    // square divided by six, via reciprocal multiply
                    op.issue = 1'b1;
                    op.first = 1'b1;
                    op.last  = 1'b1;
                    op.shift = mlf_pkg::SHIFT_RECIP;
                    a_val    = A_W'(res_val);
                    b_val    = $signed(RECIP_B);
                end
                STEP_CUBE:
                begin
                    // out = sat(y - round(q * y))
                    op.issue    = 1'b1;
                    op.first    = 1'b1;
                    op.last     = 1'b1;
                    op.round    = 1'b1;
                    op.sub_base = 1'b1;
                    op.sat_en   = 1'b1;
                    op.shift    = mlf_pkg::SHIFT_FRAC;
                    a_val       = A_W'(res_val);
                    b_val       = B_W'(y3raw_reg);
                    base_val    = y3raw_reg;
                end
                default:
                begin
                    // each pole stage: -k*y_old, p*u_old, then p*u_new
                    for (int i = 0; i < NUM_STAGES; i++)
                    begin
                        if (step_reg == STEP_W'(S_ST0 + STAGE_STEPS * i))
                        begin
                            op.issue = 1'b1;
                            op.first = 1'b1;
                            op.neg   = 1'b1;
                            op.round = 1'b1;
                            op.shift = mlf_pkg::SHIFT_COEF;
                            a_val    = A_W'(pole_reg);
                            b_val    = B_W'(stage_reg[i]);
                        end
                        else if (step_reg == STEP_W'(S_ST0 + STAGE_STEPS * i + 1))
                        begin
                            op.issue = 1'b1;
                            op.round = 1'b1;
                            op.shift = mlf_pkg::SHIFT_COEF;
                            a_val    = $signed(A_W'(input_reg));
                            b_val    = B_W'(u_old[i]);
                        end
                        else if (step_reg == STEP_W'(S_ST0 + STAGE_STEPS * i + 2))
                        begin
                            op.issue  = 1'b1;
                            op.last   = 1'b1;
                            op.round  = 1'b1;
                            op.sat_en = 1'b1;
                            op.shift  = mlf_pkg::SHIFT_COEF;
                            a_val     = $signed(A_W'(input_reg));
                            b_val     = B_W'(res_val);
                        end
                    end
                end
            endcase
        end
    end

    mlf_mac_unit #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .a      (a_val),
        .b      (b_val),
        .base   (base_val),
        .res    (res_val),
        .status (mac_stat)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_reg  <= '0;
            input_reg <= '0;
            gain_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                mlf_pkg::CFG_POLE_COEF:     pole_reg  <= $signed(cfg.data[K_W-1:0]);
                mlf_pkg::CFG_INPUT_COEF:    input_reg <= cfg.data[P_W-1:0];
                mlf_pkg::CFG_FEEDBACK_GAIN: gain_reg  <= cfg.data[R_W-1:0];
                default:                    ;
            endcase
        end
    end

    // sequencer, history and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            prev_input_reg <= '0;
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                stage_reg[i] <= '0;
            end
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mac_stat.valid && mac_stat.sat)
            begin
                sat_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_accept)
                    begin
                        if (request.req_type == mlf_pkg::REQ_CLEAR)
                        begin
                            // clear history, registers kept, no result
                            prev_input_reg <= '0;
                            for (int i = 0; i < NUM_STAGES; i++)
                            begin
                                stage_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                            step_reg  <= '0;
                            sat_reg   <= 1'b0;
                        end
                    end
                end
                ST_RUN:
                begin
                    // write back each value once its old copy is no longer read
                    if (step_reg == STEP_X_CAPT)
                    begin
                        prev_input_reg <= res_val[SAMPLE_BITS-1:0];
                    end
                    for (int i = 0; i < NUM_STAGES - 1; i++)
                    begin
                        if (step_reg == STEP_W'(S_ST0 + STAGE_STEPS * i +
                                                STAGE_STEPS - 1 + MAC_LAT))
                        begin
                            stage_reg[i] <= res_val[SAMPLE_BITS-1:0];
                        end
                    end

                    if (step_reg != STEP_DONE)
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                    else if (slot_free)
                    begin
                        // clipped output becomes both the result and the feedback
                        stage_reg[NUM_STAGES-1] <= res_val[SAMPLE_BITS-1:0];
                        out_sample_reg          <= res_val[SAMPLE_BITS-1:0];
                        out_sat_reg             <= sat_reg | mac_stat.sat;
                        out_valid_reg           <= 1'b1;
                        state_reg               <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // per-request payload captures
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            sample_reg <= request.sample_in;
        end
        if (state_reg == ST_RUN && step_reg == STEP_SQ)
        begin
            y3raw_reg <= res_val[SAMPLE_BITS-1:0];
        end
    end

endmodule
